// ===== src/tcse_pkg.sv =====
// Shared types and constants for the text console scroll engine.
package tcse_pkg;

  localparam int DEF_COLUMNS     = 12;
  localparam int DEF_LINES       = 4;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam int LINE_FW = 2;
  localparam int COL_FW  = 4;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;

  typedef enum logic [1:0] {
    ACT_ENQUEUE     = 2'd0,
    ACT_TICK        = 2'd1,
    ACT_CLEAR_ALL   = 2'd2,
    ACT_CLEAR_QUEUE = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [CHAR_W-1:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [LINE_FW-1:0] cell_line;
    logic [COL_FW-1:0]  cell_column;
    logic [CHAR_W-1:0]  cell_char;
    logic               highlight;
    logic               last_draw;
  } out_item_t;

  // One cell draw on its way to the output register.
  typedef struct packed {
    out_item_t item;
    logic      use_ram;
    logic      written;
  } draw_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [CHAR_W-1:0] code;
  } queue_cmd_t;

endpackage

// ===== src/text_console_scroll_engine.sv =====
// Text console scroll engine: enqueue, clear and a tick with nothing to do leave it idle. A tick
// that prints goes to S_DRAW (through S_POP first when it pops the queue) before the next item;
// a repaint tick draws one cell on every line of its column. Draws leave at one a cycle while
// draw_stall is low, set by the single read port of the text RAM; each passes the RAM read stage
// and the output register. Reset clears all control state at once with no clearing pass: cells
// read as space unless they lie before the cursor, and a scroll rotates the line offset instead.
module text_console_scroll_engine import tcse_pkg::*; #(
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int LINES       = DEF_LINES,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      draw_valid,
  input  logic      draw_stall,
  output out_item_t draw
);

  localparam int LW  = $clog2(LINES);
  localparam int CW  = $clog2(COLUMNS);
  localparam int CCW = $clog2(COLUMNS + 1);
  localparam int AW  = $clog2(LINES * COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DRAW = 3'b100
  } state_t;

  state_t             state;
  logic [LW-1:0]      cur_line;
  logic [CCW-1:0]     cur_col;
  logic [LW-1:0]      top;
  logic               scrolling;
  logic [CCW-1:0]     rp_col;
  logic [CHAR_W-1:0]  held_char;
  logic               held_valid;
  logic               prev_valid;
  logic [LW-1:0]      prev_line;
  logic [CW-1:0]      prev_col;
  logic               repaint_mode;
  logic [LW-1:0]      k;
  logic [CHAR_W-1:0]  pch;

  logic               accept;
  logic               is_tick;
  queue_cmd_t         qcmd;
  logic               q_empty;
  logic [CHAR_W-1:0]  q_rdata;

  logic               start_print;
  logic [CHAR_W-1:0]  start_char;
  logic               overflow;
  logic               nl_scroll;
  logic [LW-1:0]      top_inc;
  logic [CCW-1:0]     rp_next;

  logic               is_prev;
  logic               is_last;
  logic [LW-1:0]      sel_line;
  logic [CW-1:0]      sel_col;
  logic [LW:0]        phys_sum;
  logic [LW-1:0]      phys;
  logic [AW-1:0]      addr;
  draw_t              cur_draw;
  logic               pipe_ready;
  logic               issue;
  logic               text_we;
  logic [CHAR_W-1:0]  text_rdata;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_tick    = accept && (item.action == ACT_TICK);

  assign qcmd.push  = accept && (item.action == ACT_ENQUEUE);
  assign qcmd.clear = accept && ((item.action == ACT_CLEAR_ALL) ||
                                 (item.action == ACT_CLEAR_QUEUE));
  assign qcmd.pop   = is_tick && !scrolling && !held_valid && !q_empty;
  assign qcmd.code  = item.char_code;

  tcse_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .cmd   (qcmd),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // A print starts from the held character on a tick, or from the queue in the cycle after the pop.
  assign start_print = (state == S_POP) || (is_tick && !scrolling && held_valid);
  assign start_char  = (state == S_POP) ? q_rdata : held_char;
  assign overflow    = (cur_col >= CCW'(COLUMNS));
  assign nl_scroll   = overflow && (cur_line == LW'(LINES - 1));
  assign top_inc     = (top == LW'(LINES - 1)) ? '0 : LW'(top + 1'b1);
  assign rp_next     = CCW'(rp_col + 1'b1);

  // Select the cell of the current draw.
  always_comb begin
    is_prev  = !repaint_mode && prev_valid && (k == '0);
    is_last  = repaint_mode ? (k == LW'(LINES - 1)) : !is_prev;
    sel_line = repaint_mode ? k : (is_prev ? prev_line : cur_line);
    sel_col  = repaint_mode ? rp_col[CW-1:0] : (is_prev ? prev_col : cur_col[CW-1:0]);
    phys_sum = {1'b0, sel_line} + {1'b0, top};
    if (phys_sum >= (LW + 1)'(LINES)) begin
      phys = LW'(phys_sum - (LW + 1)'(LINES));
    end else begin
      phys = phys_sum[LW-1:0];
    end
    addr = AW'(AW'(phys) * AW'(COLUMNS)) + AW'(sel_col);

    cur_draw.item.cell_line   = LINE_FW'(sel_line);
    cur_draw.item.cell_column = COL_FW'(sel_col);
    cur_draw.item.cell_char   = pch;
    cur_draw.item.highlight   = !repaint_mode && !is_prev;
    cur_draw.item.last_draw   = is_last;
    cur_draw.use_ram          = repaint_mode || is_prev;
    cur_draw.written          = (sel_line < cur_line) ||
                                ((sel_line == cur_line) && (CCW'(sel_col) < cur_col));
  end

  assign issue   = (state == S_DRAW) && pipe_ready;
  assign text_we = issue && !repaint_mode && is_last;

  tcse_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINES * COLUMNS)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (addr),
    .wdata (pch),
    .re    (issue && cur_draw.use_ram),
    .raddr (addr),
    .rdata (text_rdata)
  );

  tcse_out u_out (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_draw (cur_draw),
    .ram_rdata  (text_rdata),
    .ready      (pipe_ready),
    .draw_valid (draw_valid),
    .draw       (draw),
    .draw_stall (draw_stall)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_line     <= '0;
      cur_col      <= '0;
      top          <= '0;
      scrolling    <= 1'b0;
      rp_col       <= '0;
      held_char    <= '0;
      held_valid   <= 1'b0;
      prev_valid   <= 1'b0;
      prev_line    <= '0;
      prev_col     <= '0;
      repaint_mode <= 1'b0;
      k            <= '0;
      pch          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.action)
              ACT_TICK: begin
                if (scrolling) begin
                  if (rp_col < CCW'(COLUMNS)) begin
                    repaint_mode <= 1'b1;
                    k            <= '0;
                    state        <= S_DRAW;
                  end else begin
                    scrolling <= 1'b0;
                  end
                end else if (!held_valid && !q_empty) begin
                  state <= S_POP;
                end
              end
              ACT_CLEAR_ALL: begin
                cur_line   <= '0;
                cur_col    <= '0;
                top        <= '0;
                scrolling  <= 1'b0;
                rp_col     <= '0;
                held_char  <= '0;
                held_valid <= 1'b0;
                prev_valid <= 1'b0;
              end
              ACT_CLEAR_QUEUE: begin
                scrolling  <= 1'b0;
                rp_col     <= '0;
                held_char  <= '0;
                held_valid <= 1'b0;
                prev_valid <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          state <= S_IDLE;
        end
        S_DRAW: begin
          if (issue) begin
            if (!is_last) begin
              k <= LW'(k + 1'b1);
            end else begin
              state <= S_IDLE;
              if (repaint_mode) begin
                rp_col <= rp_next;
                if (rp_next >= CCW'(COLUMNS)) begin
                  scrolling <= 1'b0;
                end
              end else begin
                prev_valid <= 1'b1;
                prev_line  <= cur_line;
                prev_col   <= cur_col[CW-1:0];
                cur_col    <= CCW'(cur_col + 1'b1);
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (start_print) begin
        if (nl_scroll) begin
          // rotate lines up, blank the bottom line, hold the character for after the repaint
          top        <= top_inc;
          cur_col    <= '0;
          scrolling  <= 1'b1;
          rp_col     <= '0;
          held_char  <= start_char;
          held_valid <= 1'b1;
          state      <= S_IDLE;
        end else begin
          if (overflow) begin
            cur_line <= LW'(cur_line + 1'b1);
            cur_col  <= '0;
          end
          held_valid   <= 1'b0;
          pch          <= start_char;
          repaint_mode <= 1'b0;
          k            <= '0;
          state        <= S_DRAW;
        end
      end
    end
  end

endmodule

// ===== src/tcse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tcse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcse_queue.sv =====
// Character queue: pointers and fill count around a queue RAM, oldest dropped when full.
module tcse_queue import tcse_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_cmd_t        cmd,
  output logic              empty,
  output logic [CHAR_W-1:0] rdata
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [FW-1:0] fill;
  logic          full;
  logic          do_push;
  logic          drop;
  logic [QW-1:0] head_inc;
  logic [QW-1:0] tail_inc;

  assign empty    = (fill == '0);
  assign full     = (fill == FW'(QUEUE_DEPTH));
  assign do_push  = cmd.push && (cmd.code != NUL_CHAR);
  assign drop     = do_push && full;
  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head + 1'b1);
  assign tail_inc = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(tail + 1'b1);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (do_push) begin
      tail <= tail_inc;
      // full: drop the oldest, fill stays
      if (drop) begin
        head <= head_inc;
      end else begin
        fill <= FW'(fill + 1'b1);
      end
    end else if (cmd.pop) begin
      head <= head_inc;
      fill <= FW'(fill - 1'b1);
    end
  end

  tcse_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail),
    .wdata (cmd.code),
    .re    (cmd.pop),
    .raddr (head),
    .rdata (rdata)
  );

endmodule

// ===== src/tcse_out.sv =====
// Draw pipeline: RAM read stage followed by the output register.
module tcse_out import tcse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              issue,
  input  draw_t             issue_draw,
  input  logic [CHAR_W-1:0] ram_rdata,
  output logic              ready,
  output logic              draw_valid,
  output out_item_t         draw,
  input  logic              draw_stall
);

  logic      pend;
  draw_t     pend_draw;
  logic      load;
  out_item_t load_item;

  assign load  = pend && (!draw_valid || !draw_stall);
  assign ready = !pend || load;

  always_comb begin
    load_item = pend_draw.item;
    if (pend_draw.use_ram) begin
      // cells never written since the last blanking read as space
      load_item.cell_char = pend_draw.written ? ram_rdata : SPACE_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      draw_valid <= 1'b0;
    end else begin
      if (issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        draw_valid <= 1'b1;
      end else if (!draw_stall) begin
        draw_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_draw <= issue_draw;
    end
    if (load) begin
      draw <= load_item;
    end
  end

endmodule

// ===== verif/text_console_scroll_engine_tb.sv =====
// Self-checking testbench for the text console scroll engine: queue, print and scroll repaint.
`timescale 1ns / 100ps
module text_console_scroll_engine_tb;
  import tcse_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int LINES       = DEF_LINES;
  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Tracks the console contents and holds the cell draws still to arrive.
  class screen_draw_checker;
    out_item_t           draws_due[$];
    out_item_t           batch[$];
    int                  errors;
    logic [CHAR_W-1:0]   char_fifo[QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head;
    logic [QPTR_W-1:0]   tail;
    logic [QPTR_W:0]     fill;
    logic [CHAR_W-1:0]   screen[LINES*COLUMNS];
    logic [LINE_FW-1:0]  cur_line;
    logic [COL_FW-1:0]   cur_col;
    logic                scrolling;
    logic [COL_FW-1:0]   repaint_col;
    logic [CHAR_W-1:0]   held_char;
    logic                held_valid;
    logic                prev_valid;
    logic [LINE_FW-1:0]  prev_line;
    logic [COL_FW-1:0]   prev_col;

    function new();
      errors = 0;
      drop_queue();
      blank_screen();
    endfunction

    function void drop_queue();
      head        = '0;
      tail        = '0;
      fill        = '0;
      scrolling   = 1'b0;
      repaint_col = '0;
      held_char   = NUL_CHAR;
      held_valid  = 1'b0;
      prev_valid  = 1'b0;
    endfunction

    function void blank_screen();
      for (int i = 0; i < LINES*COLUMNS; i++) screen[i] = SPACE_CHAR;
      cur_line = '0;
      cur_col  = '0;
    endfunction

    function void add_draw(logic [LINE_FW-1:0] ln, logic [COL_FW-1:0] col,
                           logic [CHAR_W-1:0] ch, logic hl);
      out_item_t d;
      d.cell_line   = ln;
      d.cell_column = col;
      d.cell_char   = ch;
      d.highlight   = hl;
      d.last_draw   = 1'b0;
      batch.push_back(d);
    endfunction

    // Wrap the cursor; on the bottom line shift the text up and start a repaint.
    function void advance_line();
      cur_col = '0;
      if (int'(cur_line) == LINES-1) begin
        for (int i = 0; i < (LINES-1)*COLUMNS; i++) screen[i] = screen[i+COLUMNS];
        for (int i = 0; i < COLUMNS; i++) screen[(LINES-1)*COLUMNS+i] = SPACE_CHAR;
        scrolling   = 1'b1;
        repaint_col = '0;
      end else begin
        cur_line = cur_line + 1'b1;
      end
    endfunction

    function void print_cell(logic [CHAR_W-1:0] ch);
      if (prev_valid)
        add_draw(prev_line, prev_col, screen[int'(prev_line)*COLUMNS + int'(prev_col)], 1'b0);
      screen[int'(cur_line)*COLUMNS + int'(cur_col)] = ch;
      add_draw(cur_line, cur_col, ch, 1'b1);
      prev_valid = 1'b1;
      prev_line  = cur_line;
      prev_col   = cur_col;
      cur_col    = cur_col + 1'b1;
    endfunction

    function void repaint_step();
      if (int'(repaint_col) < COLUMNS) begin
        for (int ln = 0; ln < LINES; ln++)
          add_draw(LINE_FW'(ln), repaint_col, screen[ln*COLUMNS + int'(repaint_col)], 1'b0);
        repaint_col = repaint_col + 1'b1;
      end
      if (int'(repaint_col) >= COLUMNS) scrolling = 1'b0;
    endfunction

    function void run_tick();
      logic [CHAR_W-1:0] ch;
      if (scrolling) begin
        repaint_step();
        return;
      end
      if (held_valid) begin
        if (int'(cur_col) > COLUMNS-1) begin
          advance_line();
          if (scrolling) return;
        end
        held_valid = 1'b0;
        print_cell(held_char);
        return;
      end
      if (fill == 0) return;
      ch   = char_fifo[head];
      head = head + 1'b1;
      fill = fill - 1'b1;
      if (int'(cur_col) > COLUMNS-1) begin
        // hold the character while the repaint runs
        held_char  = ch;
        held_valid = 1'b1;
        advance_line();
        if (scrolling) return;
        held_valid = 1'b0;
      end
      print_cell(ch);
    endfunction

    function void note_item(in_item_t it);
      out_item_t tail_draw;
      batch.delete();
      case (it.action)
        ACT_ENQUEUE: begin
          if (it.char_code != NUL_CHAR) begin
            // drop the oldest entry when full
            if (int'(fill) >= QUEUE_DEPTH) begin
              head = head + 1'b1;
              fill = fill - 1'b1;
            end
            char_fifo[tail] = it.char_code;
            tail = tail + 1'b1;
            fill = fill + 1'b1;
          end
        end
        ACT_TICK: run_tick();
        ACT_CLEAR_ALL: begin
          blank_screen();
          drop_queue();
        end
        default: drop_queue();
      endcase
      if (batch.size() != 0) begin
        tail_draw = batch.pop_back();
        tail_draw.last_draw = 1'b1;
        batch.push_back(tail_draw);
      end
      foreach (batch[i]) draws_due.push_back(batch[i]);
    endfunction

    function void check_draw(out_item_t got);
      out_item_t want;
      if (draws_due.size() == 0) begin
        $error("unexpected draw: line %0d column %0d char %0d", got.cell_line,
               got.cell_column, got.cell_char);
        errors++;
        return;
      end
      want = draws_due.pop_front();
      if (got.cell_line !== want.cell_line) begin
        $error("cell_line: expected %0d, got %0d", want.cell_line, got.cell_line);
        errors++;
      end
      if (got.cell_column !== want.cell_column) begin
        $error("cell_column: expected %0d, got %0d", want.cell_column, got.cell_column);
        errors++;
      end
      if (got.cell_char !== want.cell_char) begin
        $error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
        errors++;
      end
      if (got.highlight !== want.highlight) begin
        $error("highlight: expected %0d, got %0d", want.highlight, got.highlight);
        errors++;
      end
      if (got.last_draw !== want.last_draw) begin
        $error("last_draw: expected %0d, got %0d", want.last_draw, got.last_draw);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst        = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item       = '0;
  logic      draw_valid;
  logic      draw_stall = 1'b0;
  out_item_t draw;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  screen_draw_checker sb;

  text_console_scroll_engine u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .draw_valid (draw_valid),
    .draw_stall (draw_stall),
    .draw       (draw)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    draw_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (draw_valid && !draw_stall) sb.check_draw(draw);
    end
  end

  function automatic in_item_t pack_item(action_t act, logic [CHAR_W-1:0] code);
    in_item_t it;
    it.action    = act;
    it.char_code = code;
    return it;
  endfunction

  // Hold valid high across back-to-back items; lower it only for an idle gap.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic run_random(input int budget);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(pack_item(ACT_CLEAR_QUEUE, 8'($urandom)));
        sent++;
      end else if (pick < 4) begin
        send_item(pack_item(ACT_CLEAR_ALL, 8'($urandom)));
        sent++;
      end else begin
        // burst of characters, then a run of ticks to print and scroll them
        n = $urandom_range(1, 18);
        repeat (n) begin
          if (sent < budget) begin
            if ($urandom_range(19) == 0) begin
              send_item(pack_item(ACT_ENQUEUE, NUL_CHAR));
            end else begin
              send_item(pack_item(ACT_ENQUEUE, 8'($urandom_range(1, 255))));
            end
            sent++;
          end
        end
        n = $urandom_range(1, 22);
        repeat (n) begin
          if (sent < budget) begin
            send_item(pack_item(ACT_TICK, 8'($urandom)));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    int waited;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(pack_item(ACT_TICK, 8'h00));
    send_item(pack_item(ACT_ENQUEUE, NUL_CHAR));
    send_item(pack_item(ACT_ENQUEUE, 8'hFF));
    send_item(pack_item(ACT_TICK, 8'hFF));
    send_item(pack_item(ACT_ENQUEUE, 8'h01));
    send_item(pack_item(ACT_TICK, 8'h00));
    send_item(pack_item(ACT_ENQUEUE, 8'h41));
    send_item(pack_item(ACT_CLEAR_QUEUE, 8'h00));
    send_item(pack_item(ACT_TICK, 8'h00));
    send_item(pack_item(ACT_ENQUEUE, 8'h42));
    send_item(pack_item(ACT_TICK, 8'h00));
    send_item(pack_item(ACT_CLEAR_ALL, 8'hFF));
    send_item(pack_item(ACT_ENQUEUE, 8'h80));
    send_item(pack_item(ACT_ENQUEUE, 8'h7F));
    send_item(pack_item(ACT_TICK, 8'h00));
    send_item(pack_item(ACT_TICK, 8'h00));

    run_random(99);
    send_idle_pct = 64;
    run_random(99);
    send_idle_pct  = 0;
    recv_stall_pct = 64;
    run_random(99);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    run_random(99);
    item_valid <= 1'b0;

    waited = 0;
    while (sb.draws_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (sb.draws_due.size() != 0) begin
      $error("%0d draws never arrived", sb.draws_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
